@@ hdl/hms_pkg.sv @@
// package for the hms time text parser
// shared widths, character codes, millisecond scales and the snapshot struct
// no dependencies
package hms_pkg;

    localparam int HOURS_MAX_DIGITS = 7;
    localparam int SHORT_MAX_DIGITS = 2;
    localparam int LEN_CAP          = HOURS_MAX_DIGITS + 1;
    localparam int LEN_W            = $clog2(LEN_CAP + 1);
    localparam int FIELD_W          = 24;
    localparam int SHORT_W          = 7;
    localparam int FRAC_W           = 10;
    localparam int FRAC_CAP         = 1000;
    localparam int FRAC_MAX         = 999;
    localparam int MS_W             = 32;

    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [MS_W-1:0] MS_PER_SEC  = 32'd1000;
    localparam logic [MS_W-1:0] MS_PER_MIN  = 32'd60000;
    localparam logic [MS_W-1:0] MS_PER_HOUR = 32'd3600000;
    localparam logic [MS_W-1:0] MS_ERROR    = 32'hffffffff;

    typedef struct packed {
        logic                err;
        logic [FRAC_W-1:0]   frac;
        logic [SHORT_W-1:0]  sec;
        logic [SHORT_W-1:0]  min;
        logic [FIELD_W-1:0]  hour;
    } hms_snap_t;

endpackage

@@ hdl/hms_field_tracker.sv @@
// parse state of the hms time text parser: fields, lengths and fraction
// updated once per item, returns to reset after an end marker
// depends on hms_pkg
module hms_field_tracker
    import hms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  character,
    input  logic        end_of_text,
    output hms_snap_t   snap
);

    localparam logic [1:0] CNT_RESET = 2'd1;
    localparam logic [1:0] CNT_MAX   = 2'd3;

    logic               in_frac_reg, in_frac_next;
    logic               frac_stop_reg, frac_stop_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic [FIELD_W-1:0] val_reg [3];
    logic [FIELD_W-1:0] val_next [3];
    logic [LEN_W-1:0]   len_reg [3];
    logic [LEN_W-1:0]   len_next [3];
    logic [2:0]         stop_reg, stop_next;
    logic [1:0]         cnt_reg, cnt_next;

    logic               is_digit;
    logic [FRAC_W+3:0]  frac_acc;
    logic [FIELD_W-1:0] val_acc;
    logic               present1, present2;
    logic               bad0, bad1, bad2;

    assign is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    assign frac_acc = {4'b0, frac_reg} * (FRAC_W+4)'(10) + (FRAC_W+4)'(character[3:0]);
    assign val_acc  = val_reg[0] * FIELD_W'(10) + FIELD_W'(character[3:0]);

    always_comb
    begin
        in_frac_next   = in_frac_reg;
        frac_stop_next = frac_stop_reg;
        frac_next      = frac_reg;
        val_next       = val_reg;
        len_next       = len_reg;
        stop_next      = stop_reg;
        cnt_next       = cnt_reg;
        if (step)
        begin
            if (end_of_text)
            begin
                in_frac_next   = 1'b0;
                frac_stop_next = 1'b0;
                frac_next      = '0;
                for (int i = 0; i < 3; i++)
                begin
                    val_next[i] = '0;
                    len_next[i] = '0;
                end
                stop_next = '0;
                cnt_next  = CNT_RESET;
            end
            else if (in_frac_reg)
            begin
                if (!frac_stop_reg)
                begin
                    if (!is_digit)
                        frac_stop_next = 1'b1;
                    else if (frac_acc > (FRAC_W+4)'(FRAC_CAP))
                        frac_next = FRAC_W'(FRAC_CAP);
                    else
                        frac_next = frac_acc[FRAC_W-1:0];
                end
            end
            else if (character == CHAR_DOT)
            begin
                in_frac_next = 1'b1;
            end
            else if (character == CHAR_COLON)
            begin
                val_next[2] = val_reg[1];
                val_next[1] = val_reg[0];
                val_next[0] = '0;
                len_next[2] = len_reg[1];
                len_next[1] = len_reg[0];
                len_next[0] = '0;
                stop_next   = {stop_reg[1:0], 1'b0};
                if (cnt_reg != CNT_MAX)
                    cnt_next = cnt_reg + 2'd1;
            end
            else
            begin
                if (len_reg[0] < LEN_W'(LEN_CAP))
                    len_next[0] = len_reg[0] + LEN_W'(1);
                if (!stop_reg[0])
                begin
                    if (!is_digit)
                        stop_next[0] = 1'b1;
                    else
                        val_next[0] = val_acc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frac_reg   <= 1'b0;
            frac_stop_reg <= 1'b0;
            frac_reg      <= '0;
            for (int i = 0; i < 3; i++)
            begin
                val_reg[i] <= '0;
                len_reg[i] <= '0;
            end
            stop_reg <= '0;
            cnt_reg  <= CNT_RESET;
        end
        else
        begin
            in_frac_reg   <= in_frac_next;
            frac_stop_reg <= frac_stop_next;
            frac_reg      <= frac_next;
            val_reg       <= val_next;
            len_reg       <= len_next;
            stop_reg      <= stop_next;
            cnt_reg       <= cnt_next;
        end
    end

    // seconds, minutes and hours from the right; missing fields are not checked
    assign present1 = (cnt_reg >= 2'd2);
    assign present2 = (cnt_reg == CNT_MAX);
    assign bad0 = (len_reg[0] == '0) || (len_reg[0] > LEN_W'(SHORT_MAX_DIGITS));
    assign bad1 = (len_reg[1] == '0) || (len_reg[1] > LEN_W'(SHORT_MAX_DIGITS));
    assign bad2 = (len_reg[2] == '0) || (len_reg[2] > LEN_W'(HOURS_MAX_DIGITS));

    always_comb
    begin
        snap.err  = (frac_reg > FRAC_W'(FRAC_MAX)) || bad0 || (present1 && bad1)
                    || (present2 && bad2);
        snap.frac = frac_reg;
        snap.sec  = val_reg[0][SHORT_W-1:0];
        snap.min  = present1 ? val_reg[1][SHORT_W-1:0] : '0;
        snap.hour = present2 ? val_reg[2] : '0;
    end

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd0)
        else $error("field count left its range");

    a_frac_cap: assert property (@(posedge clk) disable iff (!rst_n)
        frac_reg <= FRAC_W'(FRAC_CAP))
        else $error("fraction passed its saturation value");

    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg[0] <= LEN_W'(LEN_CAP) && len_reg[1] <= LEN_W'(LEN_CAP)
        && len_reg[2] <= LEN_W'(LEN_CAP))
        else $error("field length passed its saturation value");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && end_of_text) |=> (cnt_reg == CNT_RESET && !in_frac_reg
        && frac_reg == '0 && stop_reg == '0 && len_reg[0] == '0))
        else $error("state not cleared after end marker");

endmodule

@@ hdl/hms_time_sum.sv @@
// millisecond sum of the hms time text parser
// product register then result register, both move on adv
// depends on hms_pkg
module hms_time_sum
    import hms_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             snap_valid,
    input  hms_snap_t        snap,
    output logic             out_valid,
    output logic [MS_W-1:0]  milliseconds,
    output logic             parse_error
);

    logic             prod_valid_reg;
    logic             prod_err_reg;
    logic [MS_W-1:0]  p_frac_reg, p_sec_reg, p_min_reg, p_hour_reg;
    logic             out_valid_reg;
    logic [MS_W-1:0]  ms_reg, ms_next;
    logic             err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            prod_valid_reg <= snap_valid;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && snap_valid)
        begin
            prod_err_reg <= snap.err;
            p_frac_reg   <= MS_W'(snap.frac);
            p_sec_reg    <= MS_W'(snap.sec) * MS_PER_SEC;
            p_min_reg    <= MS_W'(snap.min) * MS_PER_MIN;
            p_hour_reg   <= MS_W'(snap.hour) * MS_PER_HOUR;
        end
        if (adv && prod_valid_reg)
        begin
            ms_reg  <= ms_next;
            err_reg <= prod_err_reg;
        end
    end

    // wraps modulo 2^32
    always_comb
    begin
        if (prod_err_reg)
            ms_next = MS_ERROR;
        else
            ms_next = p_frac_reg + p_sec_reg + p_min_reg + p_hour_reg;
    end

    assign out_valid    = out_valid_reg;
    assign milliseconds = ms_reg;
    assign parse_error  = err_reg;

endmodule

@@ hdl/hms_time_text_parser.sv @@
// Time text parser: takes "H:MM:SS.mmm" one character per item, then an end
// marker item, and returns the time in milliseconds (0xffffffff with
// parse_error set when a field is empty or too long or the fraction is above
// 999). One item is accepted every cycle unless the output stalls; the result
// of an end marker passes through the input register, the product register
// and the result register before it shows on out_valid. A stall on the
// output freezes the whole pipeline.
module hms_time_text_parser
    import hms_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       character,
    input  logic             end_of_text,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [MS_W-1:0]  milliseconds,
    output logic             parse_error
);

    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       eot_reg;
    logic       adv;
    hms_snap_t  snap;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (adv)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            char_reg <= character;
            eot_reg  <= end_of_text;
        end
    end

    hms_field_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (adv && in_valid_reg),
        .character   (char_reg),
        .end_of_text (eot_reg),
        .snap        (snap)
    );

    hms_time_sum u_sum (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .snap_valid   (in_valid_reg && eot_reg),
        .snap         (snap),
        .out_valid    (out_valid),
        .milliseconds (milliseconds),
        .parse_error  (parse_error)
    );

endmodule

@@ test/tb_top.sv @@
// testbench for hms_time_text_parser: queue-fed driver, monitor and an item-level
// predictor of the parse, with random idling on both handshakes
// depends on hms_pkg and hms_time_text_parser
module tb_top;
    import hms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TEXT_ITEMS     = 700;
    localparam int CALM_TAIL      = 80;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } text_item_t;

    typedef struct packed {
        logic [MS_W-1:0] ms;
        logic            err;
    } parse_result_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    logic [7:0]      character = 8'h00;
    logic            end_of_text = 1'b0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [MS_W-1:0] milliseconds;
    logic            parse_error;

    text_item_t    pending_chars[$];
    parse_result_t expected_times[$];

    // parse state
    logic              frac_seen;
    logic              frac_stop;
    logic [FRAC_W-1:0] frac_ms;
    logic [31:0]       seg_val[3];
    logic [3:0]        seg_len[3];
    logic              seg_stop[3];
    int unsigned       seg_count;

    int mismatches   = 0;
    int quiet_cycles = 0;
    int in_gap       = 0;
    int in_odds      = 0;
    int out_gap      = 0;
    int out_odds     = 0;
    logic calm       = 1'b0;

    hms_time_text_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .character    (character),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .milliseconds (milliseconds),
        .parse_error  (parse_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= CHAR_ZERO && ch <= CHAR_NINE;
    endfunction

    task automatic clear_parse();
        frac_seen = 1'b0;
        frac_stop = 1'b0;
        frac_ms   = '0;
        for (int i = 0; i < 3; i++)
        begin
            seg_val[i]  = '0;
            seg_len[i]  = '0;
            seg_stop[i] = 1'b0;
        end
        seg_count = 1;
    endtask

    task automatic advance_parse(input logic [7:0] ch, input logic eot);
        int unsigned   grown;
        logic          bad;
        logic [31:0]   total;
        logic [31:0]   scale;
        int unsigned   lim;
        parse_result_t res;
        if (!eot)
        begin
            if (frac_seen)
            begin
                if (!frac_stop)
                begin
                    if (!is_digit(ch))
                        frac_stop = 1'b1;
                    else
                    begin
                        grown = frac_ms * 10 + (ch - CHAR_ZERO);
                        frac_ms = (grown > FRAC_CAP) ? FRAC_W'(FRAC_CAP) : FRAC_W'(grown);
                    end
                end
            end
            else if (ch == CHAR_DOT)
                frac_seen = 1'b1;
            else if (ch == CHAR_COLON)
            begin
                for (int i = 2; i > 0; i--)
                begin
                    seg_val[i]  = seg_val[i-1];
                    seg_len[i]  = seg_len[i-1];
                    seg_stop[i] = seg_stop[i-1];
                end
                seg_val[0]  = '0;
                seg_len[0]  = '0;
                seg_stop[0] = 1'b0;
                if (seg_count < 3)
                    seg_count++;
            end
            else
            begin
                if (seg_len[0] < 4'd15)
                    seg_len[0]++;
                if (!seg_stop[0])
                begin
                    if (!is_digit(ch))
                        seg_stop[0] = 1'b1;
                    else
                        seg_val[0] = seg_val[0] * 10 + 32'(ch - CHAR_ZERO);
                end
            end
        end
        else
        begin
            bad   = frac_ms > FRAC_MAX;
            total = 32'(frac_ms);
            for (int i = 0; i < seg_count; i++)
            begin
                lim   = (i < 2) ? SHORT_MAX_DIGITS : HOURS_MAX_DIGITS;
                scale = (i == 0) ? MS_PER_SEC : (i == 1) ? MS_PER_MIN : MS_PER_HOUR;
                if (seg_len[i] < 1 || seg_len[i] > lim)
                    bad = 1'b1;
                total = total + seg_val[i] * scale;
            end
            res.ms  = bad ? MS_ERROR : total;
            res.err = bad;
            expected_times.push_back(res);
            clear_parse();
        end
    endtask

    task automatic push_char(input logic [7:0] ch);
        text_item_t it;
        it.ch  = ch;
        it.eot = 1'b0;
        pending_chars.push_back(it);
    endtask

    task automatic push_end();
        text_item_t it;
        it.ch  = 8'($urandom_range(0, 255));
        it.eot = 1'b1;
        pending_chars.push_back(it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    // mostly well-formed times with random content, the rest noise
    task automatic push_random_text();
        int kind;
        int nseg;
        int s;
        int len;
        int lim;
        int pick;
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            nseg = $urandom_range(1, 4);
            for (s = nseg - 1; s >= 0; s--)
            begin
                lim = (s == 2) ? HOURS_MAX_DIGITS : (s == 3) ? 5 : SHORT_MAX_DIGITS;
                len = $urandom_range(1, lim);
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(0, lim + 2);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        push_char(8'($urandom_range(0, 255)));
                    else
                        push_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
                end
                if (s != 0)
                    push_char(CHAR_COLON);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                push_char(CHAR_DOT);
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 5) : $urandom_range(0, 3);
                for (int k = 0; k < len; k++)
                    push_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 3) == 0)
                    push_char(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            len = $urandom_range(0, 14);
            for (int k = 0; k < len; k++)
            begin
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    push_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
                else if (pick == 1)
                    push_char(CHAR_COLON);
                else if (pick == 2)
                    push_char(CHAR_DOT);
                else
                    push_char(8'($urandom_range(0, 255)));
            end
        end
        push_end();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        text_item_t nxt;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            character   <= 8'h00;
            end_of_text <= 1'b0;
            in_gap      <= 0;
            in_odds     <= 0;
            calm        <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                advance_parse(character, end_of_text);
            if (!in_valid || !in_stall)
            begin
                if (in_gap != 0)
                begin
                    in_valid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end
                else if (!calm && in_odds != 0 && $urandom_range(0, 3 * in_odds) == 0)
                begin
                    in_valid <= 1'b0;
                    in_gap   <= $urandom_range(0, 17);
                end
                else if (pending_chars.size() != 0)
                begin
                    nxt = pending_chars.pop_front();
                    in_valid    <= 1'b1;
                    character   <= nxt.ch;
                    end_of_text <= nxt.eot;
                    if (nxt.eot)
                        in_odds <= $urandom_range(0, 3);
                end
                else
                    in_valid <= 1'b0;
            end
            calm <= pending_chars.size() < CALM_TAIL;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        parse_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
            out_odds  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                out_odds <= $urandom_range(0, 3);
                if (expected_times.size() == 0)
                begin
                    $error("unexpected item: milliseconds %0d parse_error %0b",
                           milliseconds, parse_error);
                    mismatches++;
                end
                else
                begin
                    want = expected_times.pop_front();
                    if (milliseconds !== want.ms)
                    begin
                        $error("milliseconds: expected %0d, actual %0d", want.ms, milliseconds);
                        mismatches++;
                    end
                    if (parse_error !== want.err)
                    begin
                        $error("parse_error: expected %0b, actual %0b", want.err, parse_error);
                        mismatches++;
                    end
                end
            end
            if (out_gap != 0)
            begin
                out_stall <= 1'b1;
                out_gap   <= out_gap - 1;
            end
            else if (!calm && out_odds != 0 && $urandom_range(0, 3 * out_odds) == 0)
            begin
                out_stall <= 1'b1;
                out_gap   <= $urandom_range(0, 17);
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        clear_parse();

        // empty text
        push_end();
        // leading dot, fraction above 999
        push_text(".1000");
        push_end();
        // extra field on the left, fraction ended by a colon
        push_text("9:1:2:3.4:");
        push_end();
        // zero byte as the only seconds character
        push_char(8'h00);
        push_end();
        // empty seconds after an all-ones byte
        push_char(8'hff);
        push_char(CHAR_COLON);
        push_end();

        while (pending_chars.size() < TEXT_ITEMS)
            push_random_text();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (!((pending_chars.size() == 0 && !in_valid && expected_times.size() == 0)
                 || quiet_cycles >= WATCHDOG_LIMIT))
            @(posedge clk);
        if (quiet_cycles < WATCHDOG_LIMIT)
            repeat (8) @(posedge clk);

        if (expected_times.size() != 0)
        begin
            $error("%0d expected items never arrived", expected_times.size());
            mismatches++;
        end
        if (quiet_cycles < WATCHDOG_LIMIT && mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ hms_time_text_parser.f @@
hdl/hms_pkg.sv
hdl/hms_field_tracker.sv
hdl/hms_time_sum.sv
hdl/hms_time_text_parser.sv
test/tb_top.sv
